// ----- rtl/core/qfn_pkg.sv -----
// Shared types and constants for the quad face normal projection block.
package qfn_pkg;

  // Default port width and the widest datapath word that is carried.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int MAX_W          = 32;
  localparam int DIAG_W         = MAX_W + 1;

  // Fraction bits of the unit normal (Q2.30).
  localparam int UNIT_BITS = 30;

  // Corner codes; the last corner carries the vector and triggers a result.
  localparam logic [1:0] CORNER_0    = 2'd0;
  localparam logic [1:0] CORNER_1    = 2'd1;
  localparam logic [1:0] CORNER_2    = 2'd2;
  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef logic signed [DIAG_W-1:0] diag_t;
  typedef logic signed [MAX_W-1:0]  word_t;

  // One face job: both diagonals and the vector.
  typedef struct packed {
    diag_t ax;
    diag_t ay;
    diag_t az;
    diag_t bx;
    diag_t by;
    diag_t bz;
    word_t vx;
    word_t vy;
    word_t vz;
  } job_t;

endpackage

// ----- rtl/core/qfn_front.sv -----
// Front end: takes corner requests, stores corners and forms the face diagonals.
module qfn_front import qfn_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_corner,
  input  logic [DATA_WIDTH-1:0] in_px,
  input  logic [DATA_WIDTH-1:0] in_py,
  input  logic [DATA_WIDTH-1:0] in_pz,
  input  logic [DATA_WIDTH-1:0] in_vx,
  input  logic [DATA_WIDTH-1:0] in_vy,
  input  logic [DATA_WIDTH-1:0] in_vz,
  input  logic                  job_full,
  output logic                  job_push,
  output job_t                  job_data
);

  localparam int EFF_W = (DATA_WIDTH < MAX_W) ? DATA_WIDTH : MAX_W;

  word_t px_s, py_s, pz_s;
  word_t cx_r [3];
  word_t cy_r [3];
  word_t cz_r [3];
  logic  accept;

  // Inputs are read as signed values of the effective width.
  assign px_s = word_t'($signed(in_px[EFF_W-1:0]));
  assign py_s = word_t'($signed(in_py[EFF_W-1:0]));
  assign pz_s = word_t'($signed(in_pz[EFF_W-1:0]));

  assign accept   = in_push && !job_full;
  assign in_full  = job_full;
  assign job_push = accept && (in_corner == CORNER_LAST);

  // Corner store; the first three corners overwrite their slots.
  always_ff @(posedge clk) begin
    if (accept && (in_corner != CORNER_LAST)) begin
      cx_r[in_corner] <= px_s;
      cy_r[in_corner] <= py_s;
      cz_r[in_corner] <= pz_s;
    end
  end

  // Diagonals a = c2 - c0 and b = c3 - c1, exact in one extra bit.
  always_comb begin
    job_data.ax = diag_t'(cx_r[CORNER_2]) - diag_t'(cx_r[CORNER_0]);
    job_data.ay = diag_t'(cy_r[CORNER_2]) - diag_t'(cy_r[CORNER_0]);
    job_data.az = diag_t'(cz_r[CORNER_2]) - diag_t'(cz_r[CORNER_0]);
    job_data.bx = diag_t'(px_s) - diag_t'(cx_r[CORNER_1]);
    job_data.by = diag_t'(py_s) - diag_t'(cy_r[CORNER_1]);
    job_data.bz = diag_t'(pz_s) - diag_t'(cz_r[CORNER_1]);
    job_data.vx = word_t'($signed(in_vx[EFF_W-1:0]));
    job_data.vy = word_t'($signed(in_vy[EFF_W-1:0]));
    job_data.vz = word_t'($signed(in_vz[EFF_W-1:0]));
  end

endmodule

// ----- rtl/core/qfn_job_fifo.sv -----
// Two-entry job queue between the front end and the projection engine.
module qfn_job_fifo import qfn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  output logic valid,
  input  logic pop,
  output job_t pop_data
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/qfn_back.sv -----
// Projection engine: cross product, normalization, square root, division, projection.
module qfn_back import qfn_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  input  job_t                  job_data,
  output logic                  job_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [DATA_WIDTH-1:0] out_tx,
  output logic [DATA_WIDTH-1:0] out_ty,
  output logic [DATA_WIDTH-1:0] out_tz,
  output logic                  out_degenerate
);

  localparam int EFF_W = (DATA_WIDTH < MAX_W) ? DATA_WIDTH : MAX_W;
  localparam logic signed [44:0] SAT_HI = 45'((64'sd1 <<< (EFF_W - 1)) - 64'sd1);
  localparam logic signed [44:0] SAT_LO = 45'(-(64'sd1 <<< (EFF_W - 1)));

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CROSS = 10'b00_0000_0010,
    S_MAG   = 10'b00_0000_0100,
    S_NORM  = 10'b00_0000_1000,
    S_SQ    = 10'b00_0001_0000,
    S_SQRT  = 10'b00_0010_0000,
    S_DIV   = 10'b00_0100_0000,
    S_DOT   = 10'b00_1000_0000,
    S_PROJ  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  logic [5:0] cnt_r;
  logic [4:0] k_r;
  logic [1:0] idx_r;

  diag_t a_r [3];
  diag_t b_r [3];
  word_t v_r [3];
  logic signed [66:0] nn_r [3];
  logic [66:0] m_r [3];
  logic        ng_r [3];
  logic [62:0] sqv_r, rt_r;
  logic [31:0] len_r, rem_r, numlo_r, quo_r;
  word_t       n_r [3];
  logic signed [66:0] s_r;
  logic signed [36:0] w_r;
  word_t       t_r [3];
  logic        deg_r;
  word_t       ot_r [3];
  logic        od_r, out_valid_r;

  logic signed [36:0] mul_a, mul_b;
  logic signed [73:0] prod_r;

  // Shared multiplier with a registered product.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Multiplier operand selection per step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CROSS: begin
        case (cnt_r)
          6'd0: begin mul_a = 37'(a_r[1]); mul_b = 37'(b_r[2]); end
          6'd1: begin mul_a = 37'(a_r[2]); mul_b = 37'(b_r[1]); end
          6'd2: begin mul_a = 37'(a_r[2]); mul_b = 37'(b_r[0]); end
          6'd3: begin mul_a = 37'(a_r[0]); mul_b = 37'(b_r[2]); end
          6'd4: begin mul_a = 37'(a_r[0]); mul_b = 37'(b_r[1]); end
          6'd5: begin mul_a = 37'(a_r[1]); mul_b = 37'(b_r[0]); end
          default: ;
        endcase
      end
      S_SQ: begin
        case (cnt_r)
          6'd0: begin mul_a = $signed({7'd0, m_r[0][29:0]}); mul_b = mul_a; end
          6'd1: begin mul_a = $signed({7'd0, m_r[1][29:0]}); mul_b = mul_a; end
          6'd2: begin mul_a = $signed({7'd0, m_r[2][29:0]}); mul_b = mul_a; end
          default: ;
        endcase
      end
      S_DOT: begin
        case (cnt_r)
          6'd0: begin mul_a = 37'(v_r[0]); mul_b = 37'(n_r[0]); end
          6'd1: begin mul_a = 37'(v_r[1]); mul_b = 37'(n_r[1]); end
          6'd2: begin mul_a = 37'(v_r[2]); mul_b = 37'(n_r[2]); end
          default: ;
        endcase
      end
      S_PROJ: begin
        case (cnt_r)
          6'd0: begin mul_a = w_r; mul_b = 37'(n_r[0]); end
          6'd1: begin mul_a = w_r; mul_b = 37'(n_r[1]); end
          6'd2: begin mul_a = w_r; mul_b = 37'(n_r[2]); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Helper values for the iterative steps.
  logic signed [66:0] prod67, s_sum;
  logic signed [36:0] w_new;
  logic [66:0] or_m;
  logic [62:0] bb, rb, rt_new;
  logic        ge_sq;
  logic [29:0] mm_sel;
  logic        ng_sel;
  logic [61:0] num_full;
  logic [32:0] trial;
  logic        ge_div;
  logic [31:0] rem_new, quo_new;
  word_t       q_signed;
  logic signed [44:0] c45, t_wide;
  word_t       v_sel, t_sat;
  logic        load_out;

  assign prod67 = $signed(prod_r[66:0]);
  assign s_sum  = s_r + prod67;
  assign w_new  = 37'((s_sum + (67'sd1 <<< (UNIT_BITS - 1))) >>> UNIT_BITS);
  assign or_m   = m_r[0] | m_r[1] | m_r[2];

  // One digit pair of the integer square root.
  assign bb     = 63'd1 << {k_r, 1'b0};
  assign rb     = rt_r + bb;
  assign ge_sq  = (sqv_r >= rb);
  assign rt_new = ge_sq ? ((rt_r >> 1) + bb) : (rt_r >> 1);

  // One quotient bit of the rounded division by the normal length.
  always_comb begin
    case (idx_r)
      2'd0:    begin mm_sel = m_r[0][29:0]; ng_sel = ng_r[0]; end
      2'd1:    begin mm_sel = m_r[1][29:0]; ng_sel = ng_r[1]; end
      default: begin mm_sel = m_r[2][29:0]; ng_sel = ng_r[2]; end
    endcase
  end
  assign num_full = {2'd0, mm_sel, 30'd0} + {31'd0, len_r[31:1]};
  assign trial    = {rem_r, numlo_r[31]};
  assign ge_div   = (trial >= {1'b0, len_r});
  assign rem_new  = ge_div ? 32'(trial - {1'b0, len_r}) : trial[31:0];
  assign quo_new  = {quo_r[30:0], ge_div};
  assign q_signed = ng_sel ? -$signed(quo_new) : $signed(quo_new);

  // Correction term and saturated tangential component.
  always_comb begin
    case (cnt_r)
      6'd1:    v_sel = v_r[0];
      6'd2:    v_sel = v_r[1];
      default: v_sel = v_r[2];
    endcase
  end
  assign c45    = 45'((prod_r + (74'sd1 <<< (UNIT_BITS - 1))) >>> UNIT_BITS);
  assign t_wide = 45'(v_sel) - c45;
  assign t_sat  = (t_wide > SAT_HI) ? word_t'(SAT_HI) :
                  (t_wide < SAT_LO) ? word_t'(SAT_LO) : word_t'(t_wide);

  assign job_pop   = (state_r == S_IDLE) && job_valid;
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_tx    = DATA_WIDTH'(ot_r[0][EFF_W-1:0]);
  assign out_ty    = DATA_WIDTH'(ot_r[1][EFF_W-1:0]);
  assign out_tz    = DATA_WIDTH'(ot_r[2][EFF_W-1:0]);
  assign out_degenerate = od_r;

  // Output valid flag: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 6'd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            a_r[0] <= job_data.ax; a_r[1] <= job_data.ay; a_r[2] <= job_data.az;
            b_r[0] <= job_data.bx; b_r[1] <= job_data.by; b_r[2] <= job_data.bz;
            v_r[0] <= job_data.vx; v_r[1] <= job_data.vy; v_r[2] <= job_data.vz;
            cnt_r   <= 6'd0;
            state_r <= S_CROSS;
          end
        end
        S_CROSS: begin
          cnt_r <= cnt_r + 6'd1;
          case (cnt_r)
            6'd1: nn_r[0] <= prod67;
            6'd2: nn_r[0] <= nn_r[0] - prod67;
            6'd3: nn_r[1] <= prod67;
            6'd4: nn_r[1] <= nn_r[1] - prod67;
            6'd5: nn_r[2] <= prod67;
            6'd6: begin
              nn_r[2] <= nn_r[2] - prod67;
              state_r <= S_MAG;
            end
            default: ;
          endcase
        end
        S_MAG: begin
          for (int i = 0; i < 3; i++) begin
            ng_r[i] <= nn_r[i][66];
            m_r[i]  <= nn_r[i][66] ? 67'(-nn_r[i]) : 67'(nn_r[i]);
          end
          if ((nn_r[0] == '0) && (nn_r[1] == '0) && (nn_r[2] == '0)) begin
            t_r[0]  <= v_r[0];
            t_r[1]  <= v_r[1];
            t_r[2]  <= v_r[2];
            deg_r   <= 1'b1;
            state_r <= S_OUT;
          end else begin
            deg_r   <= 1'b0;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // Common shift that brings the largest magnitude into [2^29, 2^30).
          if (or_m[66:30] != '0) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (!or_m[29]) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            sqv_r   <= '0;
            cnt_r   <= 6'd0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r != 6'd0) sqv_r <= sqv_r + prod_r[62:0];
          if (cnt_r == 6'd3) begin
            rt_r    <= '0;
            k_r     <= 5'd31;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (ge_sq) sqv_r <= sqv_r - rb;
          rt_r <= rt_new;
          k_r  <= k_r - 5'd1;
          if (k_r == 5'd0) begin
            len_r   <= rt_new[31:0];
            idx_r   <= 2'd0;
            cnt_r   <= 6'd0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_r == 6'd0) begin
            rem_r   <= {2'd0, num_full[61:32]};
            numlo_r <= num_full[31:0];
            quo_r   <= '0;
            cnt_r   <= 6'd1;
          end else begin
            rem_r   <= rem_new;
            numlo_r <= numlo_r << 1;
            quo_r   <= quo_new;
            if (cnt_r == 6'd32) begin
              case (idx_r)
                2'd0:    n_r[0] <= q_signed;
                2'd1:    n_r[1] <= q_signed;
                default: n_r[2] <= q_signed;
              endcase
              cnt_r <= 6'd0;
              if (idx_r == 2'd2) begin
                s_r     <= '0;
                state_r <= S_DOT;
              end else begin
                idx_r <= idx_r + 2'd1;
              end
            end else begin
              cnt_r <= cnt_r + 6'd1;
            end
          end
        end
        S_DOT: begin
          if (cnt_r != 6'd0) s_r <= s_sum;
          if (cnt_r == 6'd3) begin
            w_r     <= w_new;
            cnt_r   <= 6'd0;
            state_r <= S_PROJ;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_PROJ: begin
          cnt_r <= cnt_r + 6'd1;
          case (cnt_r)
            6'd1: t_r[0] <= t_sat;
            6'd2: t_r[1] <= t_sat;
            6'd3: begin
              t_r[2]  <= t_sat;
              state_r <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: begin
          // Hand the result to the output register once it is free.
          if (load_out) begin
            ot_r[0]     <= t_r[0];
            ot_r[1]     <= t_r[1];
            ot_r[2]     <= t_r[2];
            od_r        <= deg_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A job leaves the queue only while the engine is waiting for work.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (state_r == S_CROSS))
    else $error("job taken outside the idle state");

  // The normal length is never below 2^29 while dividing.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (len_r[31:29] != 3'd0))
    else $error("normal length out of range in division");

  // Normalization ends with the largest magnitude in [2^29, 2^30).
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SQ) && (cnt_r == 6'd0)) |-> (or_m[66:30] == '0) && or_m[29])
    else $error("magnitudes not normalized");

  // A waiting result is never overwritten unless it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> out_valid_r && $stable(od_r))
    else $error("pending result lost");
`endif

endmodule

// ----- rtl/core/quad_face_normal_vector_projection.sv -----
// Top level of the quad face normal projection block.
//
// Usage: push the four corners of a face as input requests, corner 0 to 3,
// with the vector on the corner 3 request. Corners 0 to 2 only fill the
// corner store and give no result. Each corner 3 request gives one result:
// the tangential vector t = v - (v.n) n, saturated, and a degenerate flag
// that is set, with t = v, when the face normal is exactly zero.
// Input requests are taken while in_full is low. A corner 3 request becomes
// a job in a two-entry queue. The engine takes a job only when it is idle
// and works through the cross product, a normalization shift of up to 35
// steps, the 32-step square root, three 32-step divisions, the dot product
// and the projection, a degenerate face stopping after the cross product.
// A result appears on the out_ ports while out_empty is low and leaves
// with out_pop. When the receiver stalls, the engine holds a finished result
// until the output register is free, the queue fills, and in_full rises.
// Reset empties the queue and the output register; the corner store is not
// cleared and must be written before a corner 3 request uses it.
module quad_face_normal_vector_projection import qfn_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_corner,
  input  logic [DATA_WIDTH-1:0] in_px,
  input  logic [DATA_WIDTH-1:0] in_py,
  input  logic [DATA_WIDTH-1:0] in_pz,
  input  logic [DATA_WIDTH-1:0] in_vx,
  input  logic [DATA_WIDTH-1:0] in_vy,
  input  logic [DATA_WIDTH-1:0] in_vz,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [DATA_WIDTH-1:0] out_tx,
  output logic [DATA_WIDTH-1:0] out_ty,
  output logic [DATA_WIDTH-1:0] out_tz,
  output logic                  out_degenerate
);

  logic job_push, job_full, job_valid, job_pop;
  job_t job_in, job_out;

  // Corner intake and diagonal forming.
  qfn_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk      (clk),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_corner(in_corner),
    .in_px    (in_px),
    .in_py    (in_py),
    .in_pz    (in_pz),
    .in_vx    (in_vx),
    .in_vy    (in_vy),
    .in_vz    (in_vz),
    .job_full (job_full),
    .job_push (job_push),
    .job_data (job_in)
  );

  // Job queue between front end and engine.
  qfn_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(job_in),
    .full     (job_full),
    .valid    (job_valid),
    .pop      (job_pop),
    .pop_data (job_out)
  );

  // Projection engine with its output register.
  qfn_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid),
    .job_data      (job_out),
    .job_pop       (job_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_tx        (out_tx),
    .out_ty        (out_ty),
    .out_tz        (out_tz),
    .out_degenerate(out_degenerate)
  );

endmodule
